/* design/dftms_pkg.sv */
// ----------------------------------------------------------------------------
// dftms_pkg
// Shared types, constants and twiddle generation for the DFT magnitude block.
// ----------------------------------------------------------------------------
package dftms_pkg;

  // Defaults for the top-level parameters
  localparam int POINTS_DEF      = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths of the ports
  localparam int SAMPLE_W = 16;
  localparam int BIN_W    = 6;
  localparam int MAG_W    = 23;
  localparam logic [MAG_W-1:0] MAG_MAX = 23'd4194304;

  // Twiddle format: Q1.15, held in 16-bit signed
  localparam int TWID_W = 16;
  localparam int Q_FRAC = 15;

  // Width of a bin's scaled real/imag part at the default parameters
  localparam int QW_DEF = SAMPLE_BITS_DEF + TWID_W + $clog2(POINTS_DEF) - Q_FRAC;

  // Angle arithmetic constants (Q30)
  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;

  // Frame sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CALC,
    ST_DRAIN
  } seq_state_t;

  // Magnitude unit states
  typedef enum logic [2:0] {
    M_IDLE,
    M_SQUARE,
    M_SUM,
    M_ROOT,
    M_OUT
  } mag_state_t;

  // Per-bin tags travelling with a magnitude request
  typedef struct packed {
    logic [BIN_W-1:0] bin_index;
    logic             last_bin;
  } mag_req_t;

  // Q30 value to Q15: clamp at zero, round half up, clamp at full scale
  function automatic logic [TWID_W-1:0] to_q15(input logic signed [63:0] s);
    logic [63:0] v;
    if (s < 0) begin
      v = 64'd0;
    end else begin
      v = (64'(s) + 64'd16384) >> Q_FRAC;
    end
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[TWID_W-1:0];
  endfunction

  // First-quadrant cos/sin of a Q30 angle, Taylor series to x^14 / x^15.
  // Returns {cos, sin}, both Q15 and non-negative. Elaboration use only.
  function automatic logic [2*TWID_W-1:0] twiddle_pair(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        tc;
    logic [63:0]        ts;
    logic signed [63:0] sc;
    logic signed [63:0] ss;
    x2 = (x * x) >> 30;
    tc = ((64'(ONE_Q30) * x2) >> 30) / 64'd2;
    ts = ((x * x2) >> 30) / 64'd6;
    sc = ONE_Q30 - $signed(tc);
    ss = $signed(x) - $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd12;
    ts = ((ts * x2) >> 30) / 64'd20;
    sc = sc + $signed(tc);
    ss = ss + $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd30;
    ts = ((ts * x2) >> 30) / 64'd42;
    sc = sc - $signed(tc);
    ss = ss - $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd56;
    ts = ((ts * x2) >> 30) / 64'd72;
    sc = sc + $signed(tc);
    ss = ss + $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd90;
    ts = ((ts * x2) >> 30) / 64'd110;
    sc = sc - $signed(tc);
    ss = ss - $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd132;
    ts = ((ts * x2) >> 30) / 64'd156;
    sc = sc + $signed(tc);
    ss = ss + $signed(ts);
    tc = ((tc * x2) >> 30) / 64'd182;
    ts = ((ts * x2) >> 30) / 64'd210;
    sc = sc - $signed(tc);
    ss = ss - $signed(ts);
    return {to_q15(sc), to_q15(ss)};
  endfunction

endpackage

/* design/dft_magnitude_spectrum.sv */
// ----------------------------------------------------------------------------
// dft_magnitude_spectrum
// Frame-based real-input DFT with one magnitude result per bin.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle into a POINTS-entry frame buffer. Once the
// frame is full the input stalls while bins 0 to POINTS/2-1 are computed in
// order by a single complex multiply-accumulate unit: each bin issues POINTS
// products, drains the pipeline and then hands its sums to the magnitude
// unit, waiting there while that unit is still busy. The square root of each
// bin runs in a separate unit, one result bit per cycle, overlapped with the
// next bin's accumulation. Results carry the bin number, the floor magnitude
// saturated to 2^22 and a mark on the final bin. The frame buffer needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module dft_magnitude_spectrum #(
  parameter int POINTS      = dftms_pkg::POINTS_DEF,
  parameter int SAMPLE_BITS = dftms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [dftms_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dftms_pkg::BIN_W-1:0]          out_bin_index,
  output logic [dftms_pkg::MAG_W-1:0]          out_magnitude,
  output logic                                 out_last_bin
);
  import dftms_pkg::*;

  localparam int TW     = $clog2(POINTS);
  localparam int BINS   = POINTS / 2;
  localparam int KW     = $clog2(BINS);
  localparam int PROD_W = SAMPLE_BITS + TWID_W;
  localparam int ACC_W  = SAMPLE_BITS + TWID_W + TW;
  localparam int QW     = ACC_W - Q_FRAC;
  localparam logic [TW-1:0] LAST_T = TW'(POINTS - 1);
  localparam logic [KW-1:0] LAST_K = KW'(BINS - 1);

  // Twiddle ROM, built at elaboration
  logic signed [TWID_W-1:0] cos_rom [POINTS];
  logic signed [TWID_W-1:0] sin_rom [POINTS];

  for (genvar m = 0; m < POINTS; m++) begin : g_rom
    localparam int          QUAD  = ((4 * m) / POINTS) % 4;
    localparam logic [63:0] REST  = 64'((4 * m) % POINTS);
    localparam logic [63:0] ANGLE = (HALF_PI_Q30 * REST + 64'(POINTS / 2)) / 64'(POINTS);
    localparam logic [2*TWID_W-1:0] PAIR = twiddle_pair(ANGLE);
    localparam logic signed [TWID_W-1:0] CQ = PAIR[2*TWID_W-1:TWID_W];
    localparam logic signed [TWID_W-1:0] SQ = PAIR[TWID_W-1:0];
    localparam logic signed [TWID_W-1:0] C_M =
      (QUAD == 0) ? CQ : (QUAD == 1) ? -SQ : (QUAD == 2) ? -CQ : SQ;
    localparam logic signed [TWID_W-1:0] S_M =
      (QUAD == 0) ? SQ : (QUAD == 1) ? CQ : (QUAD == 2) ? -SQ : -CQ;
    assign cos_rom[m] = C_M;
    assign sin_rom[m] = S_M;
  end

  // Sample narrowing: low SAMPLE_BITS bits, or zero-extended when wider
  logic [SAMPLE_BITS-1:0] wr_data;
  if (SAMPLE_BITS <= SAMPLE_W) begin : g_narrow
    assign wr_data = in_sample[SAMPLE_BITS-1:0];
  end else begin : g_wide
    assign wr_data = {{(SAMPLE_BITS - SAMPLE_W){1'b0}}, in_sample};
  end

  seq_state_t state_r, state_nxt;
  logic [TW-1:0] fill_r, fill_nxt;
  logic [TW-1:0] t_r, t_nxt;
  logic [TW-1:0] idx_r, idx_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [TW:0]   idx_sum;
  logic [TW:0]   idx_wrap;
  logic          wr_en;
  logic          issue;
  logic          req_valid;
  logic          req_ready;
  mag_req_t      req_info;

  // Frame buffer and pipeline registers
  logic signed [SAMPLE_BITS-1:0] frame_mem [POINTS];
  logic signed [SAMPLE_BITS-1:0] rd_r;
  logic signed [TWID_W-1:0]      tw_c_r, tw_s_r;
  logic                          s1_vld_r, s1_first_r, s1_last_r;
  logic signed [PROD_W-1:0]      prod_re_r, prod_im_r;
  logic                          s2_vld_r, s2_first_r, s2_last_r;
  logic signed [ACC_W-1:0]       re_acc_r, im_acc_r;
  logic signed [ACC_W-1:0]       pre_ext, pim_ext;
  logic                          acc_done_r;

  // Twiddle index steps by k modulo POINTS
  assign idx_sum  = {1'b0, idx_r} + (TW + 1)'(k_r);
  assign idx_wrap = (idx_sum >= (TW + 1)'(POINTS)) ? (idx_sum - (TW + 1)'(POINTS)) : idx_sum;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      fill_r  <= '0;
      t_r     <= '0;
      idx_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      t_r     <= t_nxt;
      idx_r   <= idx_nxt;
      k_r     <= k_nxt;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    t_nxt     = t_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    in_ready  = 1'b0;
    wr_en     = 1'b0;
    issue     = 1'b0;
    req_valid = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          wr_en = 1'b1;
          if (fill_r == LAST_T) begin
            fill_nxt  = '0;
            t_nxt     = '0;
            idx_nxt   = '0;
            k_nxt     = '0;
            state_nxt = ST_CALC;
          end else begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      ST_CALC: begin
        issue   = 1'b1;
        t_nxt   = t_r + 1'b1;
        idx_nxt = idx_wrap[TW-1:0];
        if (t_r == LAST_T) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        req_valid = acc_done_r;
        if (acc_done_r && req_ready) begin
          t_nxt   = '0;
          idx_nxt = '0;
          if (k_r == LAST_K) begin
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_CALC;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Frame memory write, registered read, twiddle fetch
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[fill_r] <= wr_data;
    end
    rd_r   <= frame_mem[t_r];
    tw_c_r <= cos_rom[idx_r];
    tw_s_r <= sin_rom[idx_r];
  end

  // Products
  always_ff @(posedge clk) begin
    prod_re_r <= rd_r * tw_c_r;
    prod_im_r <= rd_r * tw_s_r;
  end

  // Pipeline control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
    end
    s1_first_r <= (t_r == '0);
    s1_last_r  <= (t_r == LAST_T);
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
  end

  // Accumulate: re gets +x*C, im gets -x*S
  assign pre_ext = ACC_W'(prod_re_r);
  assign pim_ext = ACC_W'(prod_im_r);

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      re_acc_r <= s2_first_r ? pre_ext : (re_acc_r + pre_ext);
      im_acc_r <= s2_first_r ? -pim_ext : (im_acc_r - pim_ext);
    end
  end

  // Bin sums complete, waiting for the magnitude unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_done_r <= 1'b0;
    end else if (s2_vld_r && s2_last_r) begin
      acc_done_r <= 1'b1;
    end else if (req_valid && req_ready) begin
      acc_done_r <= 1'b0;
    end
  end

  assign req_info.bin_index = BIN_W'(k_r);
  assign req_info.last_bin  = (k_r == LAST_K);

  // Magnitude unit and output register
  dftms_mag #(
    .QW (QW)
  ) u_mag (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req_info      (req_info),
    .req_re        (re_acc_r[ACC_W-1:Q_FRAC]),
    .req_im        (im_acc_r[ACC_W-1:Q_FRAC]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bin_index (out_bin_index),
    .out_magnitude (out_magnitude),
    .out_last_bin  (out_last_bin)
  );

  // Checks
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && fill_r == LAST_T) |=> (state_r == ST_CALC && fill_r == '0))
    else $error("full frame did not start computation");

  a_sum_done: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && s2_last_r) |=> acc_done_r)
    else $error("last product did not complete the bin");

  a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    acc_done_r |-> (!s1_vld_r && !s2_vld_r))
    else $error("products in flight after bin completed");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_T)
    else $error("twiddle index out of range");

endmodule

/* design/dftms_mag.sv */
// ----------------------------------------------------------------------------
// dftms_mag
// Magnitude unit: squares the scaled real and imaginary parts, adds them and
// takes the floor square root one result bit per cycle, then holds the
// saturated result in the output register until it is transferred.
// ----------------------------------------------------------------------------
module dftms_mag #(
  parameter int QW = dftms_pkg::QW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  dftms_pkg::mag_req_t           req_info,
  input  logic signed [QW-1:0]          req_re,
  input  logic signed [QW-1:0]          req_im,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dftms_pkg::BIN_W-1:0]   out_bin_index,
  output logic [dftms_pkg::MAG_W-1:0]   out_magnitude,
  output logic                          out_last_bin
);
  import dftms_pkg::*;

  localparam int SUM_W = 2 * QW + 1;
  localparam int STEPS = (SUM_W + 1) / 2;
  localparam int BIT_W = 2 * STEPS;
  localparam int CMP_W = (STEPS > MAG_W) ? STEPS : MAG_W;

  mag_state_t         state_r, state_nxt;
  mag_req_t           info_r;
  logic [QW-1:0]      abs_re_r, abs_im_r;
  logic [QW-1:0]      abs_re, abs_im;
  logic [2*QW-1:0]    sq_re_r, sq_im_r;
  logic [BIT_W-1:0]   rem_r, res_r, bit_r;
  logic [BIT_W:0]     trial;
  logic               fits;
  logic [BIT_W-1:0]   res_step;
  logic [CMP_W-1:0]   root_ext;
  logic [MAG_W-1:0]   mag_r, mag_sat;

  // Absolute values of the incoming parts
  assign abs_re = req_re[QW-1] ? QW'(-req_re) : QW'(req_re);
  assign abs_im = req_im[QW-1] ? QW'(-req_im) : QW'(req_im);

  // One restoring square-root step
  assign trial    = {1'b0, res_r} + {1'b0, bit_r};
  assign fits     = {1'b0, rem_r} >= trial;
  assign res_step = fits ? ((res_r >> 1) + bit_r) : (res_r >> 1);
  assign root_ext = CMP_W'(res_step[STEPS-1:0]);
  assign mag_sat  = (root_ext > CMP_W'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshakes
  always_comb begin
    state_nxt = state_r;
    req_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      M_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_nxt = M_SQUARE;
        end
      end
      M_SQUARE: state_nxt = M_SUM;
      M_SUM:    state_nxt = M_ROOT;
      M_ROOT: begin
        if (bit_r[0]) begin
          state_nxt = M_OUT;
        end
      end
      M_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = M_IDLE;
        end
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      M_IDLE: begin
        if (req_valid) begin
          info_r   <= req_info;
          abs_re_r <= abs_re;
          abs_im_r <= abs_im;
        end
      end
      M_SQUARE: begin
        sq_re_r <= abs_re_r * abs_re_r;
        sq_im_r <= abs_im_r * abs_im_r;
      end
      M_SUM: begin
        rem_r <= BIT_W'(sq_re_r) + BIT_W'(sq_im_r);
        res_r <= '0;
        bit_r <= BIT_W'(1) << (BIT_W - 2);
      end
      M_ROOT: begin
        if (fits) begin
          rem_r <= rem_r - trial[BIT_W-1:0];
        end
        res_r <= res_step;
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          mag_r <= mag_sat;
        end
      end
      default: ;
    endcase
  end

  assign out_bin_index = info_r.bin_index;
  assign out_magnitude = mag_r;
  assign out_last_bin  = info_r.last_bin;

  // Checks
  a_root_bit_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == M_ROOT) |-> (bit_r != '0))
    else $error("square-root step with empty bit mask");

  a_root_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == M_ROOT && bit_r[0]) |=> out_valid)
    else $error("root finished but no result presented");

  a_mag_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_magnitude <= MAG_MAX))
    else $error("magnitude above saturation level");

endmodule
